@@ hdl/cpd_pkg.sv @@
package cpd_pkg;

    localparam int DEF_MAX_PAYLOAD  = 22;
    localparam int DEF_WINDOW_DEPTH = 32;

    localparam logic [5:0]  HC_RESET       = 6'd35;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL  = 16'h8408;
    localparam logic [7:0]  KEY_REPORT_CMD = 8'h80;

    // controller to datapath
    typedef struct packed {
        logic wr_byte;
        logic rd;
        logic idx_clr;
        logic idx_inc;
        logic idx_ld2;
        logic ld_cmd;
        logic crc_first;
        logic crc_upd;
        logic ld_len;
        logic ld_rxlo;
        logic drop1;
        logic drop_pkt;
        logic nres_clr;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_lt4;
        logic cmd_bad;
        logic len_bad;
        logic short_win;
        logic crc_more;
        logic crc_ok;
        logic cap_hit;
        logic out_last;
        logic out_free;
    } t_dp_stat;

    // one byte of reflected crc-16, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/cpd_ctrl.sv @@
module cpd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  cpd_pkg::t_dp_stat  i_stat,
    output cpd_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_CMD   = 8'b0000_0100,
        S_LEN   = 8'b0000_1000,
        S_CRC   = 8'b0001_0000,
        S_CRCHI = 8'b0010_0000,
        S_ERD   = 8'b0100_0000,
        S_EOUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_rx_ready = i_rst_n && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_rx_valid && o_rx_ready) begin
                    o_cmd.wr_byte  = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    o_cmd.nres_clr = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.count_lt4) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CMD;
                end
            end
            S_CMD: begin
                if (i_stat.cmd_bad) begin
                    o_cmd.drop1   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_CHECK;
                end else begin
                    o_cmd.ld_cmd    = 1'b1;
                    o_cmd.crc_first = 1'b1;
                    o_cmd.rd        = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    n_state         = S_LEN;
                end
            end
            S_LEN: begin
                if (i_stat.len_bad) begin
                    o_cmd.drop1   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_CHECK;
                end else if (i_stat.short_win) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ld_len  = 1'b1;
                    o_cmd.crc_upd = 1'b1;
                    o_cmd.rd      = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CRC;
                end
            end
            S_CRC: begin
                o_cmd.rd      = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.crc_more) begin
                    o_cmd.crc_upd = 1'b1;
                end else begin
                    o_cmd.ld_rxlo = 1'b1;
                    n_state       = S_CRCHI;
                end
            end
            S_CRCHI: begin
                if (!i_stat.crc_ok) begin
                    o_cmd.drop1   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_CHECK;
                end else if (i_stat.cap_hit) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_ld2 = 1'b1;
                    n_state       = S_ERD;
                end
            end
            S_ERD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EOUT;
            end
            S_EOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.out_last) begin
                        o_cmd.drop_pkt = 1'b1;
                        o_cmd.idx_clr  = 1'b1;
                        n_state        = S_CHECK;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/cpd_dpath.sv @@
module cpd_dpath #(
    parameter int MAX_PAYLOAD  = cpd_pkg::DEF_MAX_PAYLOAD,
    parameter int WINDOW_DEPTH = cpd_pkg::DEF_WINDOW_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpd_pkg::t_dp_cmd  i_cmd,
    output cpd_pkg::t_dp_stat o_stat,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_data,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output logic [7:0]        o_command,
    output logic [4:0]        o_payload_length,
    output logic              o_has_data,
    output logic [7:0]        o_data_byte,
    output logic [4:0]        o_byte_index,
    output logic              o_is_key_report,
    output logic              o_last
);

    localparam int MAX_RESULTS = MAX_PAYLOAD + 4;
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int IW = $clog2(MAX_PAYLOAD + 5);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    logic [7:0]    mem [WINDOW_DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_start;
    logic [CW-1:0] r_count;
    logic [5:0]    r_hc;
    logic [7:0]    r_cmd;
    logic [7:0]    r_len;
    logic [15:0]   r_crc;
    logic [7:0]    r_rxlo;
    logic [IW-1:0] r_idx;
    logic [NW-1:0] r_nres;
    logic          r_ovalid;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] pkt_len;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(WINDOW_DEPTH)) begin
            s = s - (CW+1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign rd_addr = f_wrap(r_start, CW'(r_idx));
    assign wr_addr = f_wrap(r_start, r_count);
    assign pkt_len = CW'(r_len) + CW'(4);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            mem[wr_addr] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // window bookkeeping and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_count <= '0;
            r_hc    <= cpd_pkg::HC_RESET;
        end else begin
            if (i_cfg_we) begin
                r_hc <= i_cfg_data;
            end
            if (i_cmd.wr_byte) begin
                if (r_count >= CW'(WINDOW_DEPTH)) begin
                    r_start <= f_wrap(r_start, CW'(1));
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end else if (i_cmd.drop1) begin
                r_start <= f_wrap(r_start, CW'(1));
                r_count <= r_count - CW'(1);
            end else if (i_cmd.drop_pkt) begin
                r_start <= f_wrap(r_start, pkt_len);
                r_count <= r_count - pkt_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_ld2) begin
            r_idx <= IW'(2);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.nres_clr) begin
            r_nres <= '0;
        end else if (i_cmd.out_load) begin
            r_nres <= r_nres + NW'(1);
        end
        if (i_cmd.ld_cmd) begin
            r_cmd <= r_rdata;
        end
        if (i_cmd.ld_len) begin
            r_len <= r_rdata;
        end
        if (i_cmd.ld_rxlo) begin
            r_rxlo <= r_rdata;
        end
        if (i_cmd.crc_first) begin
            r_crc <= cpd_pkg::crc_byte(cpd_pkg::CRC_INIT, r_rdata);
        end else if (i_cmd.crc_upd) begin
            r_crc <= cpd_pkg::crc_byte(r_crc, r_rdata);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_command        <= r_cmd;
            o_payload_length <= r_len[4:0];
            o_has_data       <= (r_len != 8'd0);
            o_data_byte      <= (r_len != 8'd0) ? r_rdata : 8'd0;
            o_byte_index     <= 5'(r_idx - IW'(2));
            o_is_key_report  <= (r_cmd == cpd_pkg::KEY_REPORT_CMD);
            o_last           <= o_stat.out_last;
        end
    end

    assign o_res_valid = r_ovalid;

    always_comb begin
        o_stat.count_lt4 = (r_count < CW'(4));
        o_stat.cmd_bad   = (r_rdata[5:0] > r_hc);
        o_stat.len_bad   = (9'(r_rdata) > 9'(MAX_PAYLOAD));
        o_stat.short_win = (10'(r_count) < (10'(r_rdata) + 10'd4));
        o_stat.crc_more  = (9'(r_idx) <= (9'(r_len) + 9'd2));
        o_stat.crc_ok    = ({r_rdata, r_rxlo} == ~r_crc);
        o_stat.cap_hit   = ((10'(r_nres) + ((r_len == 8'd0) ? 10'd1 : 10'(r_len)))
                            > 10'(MAX_RESULTS));
        o_stat.out_last  = (r_len == 8'd0) || (9'(r_idx) == (9'(r_len) + 9'd1));
        o_stat.out_free  = !r_ovalid || i_res_ready;
    end

endmodule

@@ hdl/command_packet_deframer_crc16.sv @@
// packet deframer for a received serial byte stream. each accepted item on
// the rx channel is one byte, appended to a circular window of WINDOW_DEPTH
// bytes. after every byte the block parses at the window start: command
// byte, length byte, payload, then crc-16/x-25 (reflected 0x1021, init
// 0xffff, complemented) low byte first over command, length and payload.
// a command whose low six bits exceed highest_command, a length above
// MAX_PAYLOAD or a crc mismatch discards one byte and parsing restarts one
// byte later. a good packet yields one result item per payload byte, or a
// single item with has_data low for a zero-length packet; last marks the
// final item and is_key_report flags command 0x80. the window sits in a
// ram with registered read, so the parser touches one byte at a time. a
// byte is accepted, then each parse attempt reads the command byte, the
// length byte, the payload and the two crc bytes in turn, stopping at the
// first rejected field or when too few bytes are held; each emitted item
// reads its byte and then waits for the output register to be free. a
// packet whose items would take the results since the last accepted byte
// past MAX_PAYLOAD+4 stops parsing and stays in the window. at most
// WINDOW_DEPTH bytes, 32 with the default parameters, are held.
// rx ready is low while a byte is being parsed and during reset.
// highest_command is written through the cfg channel, which is ready
// whenever reset is released.
module command_packet_deframer_crc16 #(
    parameter int MAX_PAYLOAD  = cpd_pkg::DEF_MAX_PAYLOAD,
    parameter int WINDOW_DEPTH = cpd_pkg::DEF_WINDOW_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // receive byte channel
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    // config write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_highest_command,
    // result channel
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_command,
    output logic [4:0] o_payload_length,
    output logic       o_has_data,
    output logic [7:0] o_data_byte,
    output logic [4:0] o_byte_index,
    output logic       o_is_key_report,
    output logic       o_last
);

    cpd_pkg::t_dp_cmd  dp_cmd;
    cpd_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = i_rst_n;

    // sequencer: parse steps, resync drops, result emission
    cpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // window ram, crc unit, field registers and output register
    cpd_dpath #(
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_data       (i_cfg_highest_command),
        .i_res_ready      (i_res_ready),
        .o_res_valid      (o_res_valid),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_has_data       (o_has_data),
        .o_data_byte      (o_data_byte),
        .o_byte_index     (o_byte_index),
        .o_is_key_report  (o_is_key_report),
        .o_last           (o_last)
    );

endmodule

@@ hdl/cpd_checker.sv @@
module cpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic [7:0] o_command,
    input logic [4:0] o_payload_length,
    input logic       o_has_data,
    input logic [7:0] o_data_byte,
    input logic [4:0] o_byte_index,
    input logic       o_is_key_report,
    input logic       o_last
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_data_byte)
            && $stable(o_byte_index) && $stable(o_command))
        else $error("result changed while stalled");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_has_data |-> o_last && o_payload_length == 5'd0
            && o_data_byte == 8'd0 && o_byte_index == 5'd0)
        else $error("bad zero-length result");

    a_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_is_key_report == (o_command == cpd_pkg::KEY_REPORT_CMD))
        else $error("key report flag mismatch");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_has_data |-> o_last == (o_byte_index + 5'd1 == o_payload_length))
        else $error("last flag misplaced");

endmodule

bind command_packet_deframer_crc16 cpd_checker u_cpd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_res_valid      (o_res_valid),
    .i_res_ready      (i_res_ready),
    .o_command        (o_command),
    .o_payload_length (o_payload_length),
    .o_has_data       (o_has_data),
    .o_data_byte      (o_data_byte),
    .o_byte_index     (o_byte_index),
    .o_is_key_report  (o_is_key_report),
    .o_last           (o_last)
);
